@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file sga_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SGA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SGA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/sga_pkg.sv @@
package sga_pkg;

   localparam int MAX_PARTICLES_DEF = 64;
   localparam int NEWTON_STEPS_DEF = 3;

   localparam int COORD_W = 32;
   localparam int MASS_W = 32;
   localparam int ACC_W = 48;
   localparam int SLOT_W = 6;
   localparam int COUNT_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int ENTRY_W = MASS_W + 3 * COORD_W;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SOFTENING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE = 2'd1;

   typedef struct packed {
      logic                       req_type;
      logic [SLOT_W-1:0]          slot;
      logic [MASS_W-1:0]          body_mass;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
   } sga_req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] acc_x;
      logic signed [ACC_W-1:0] acc_y;
      logic signed [ACC_W-1:0] acc_z;
      logic                    overflow_flag;
   } sga_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_EPS, ST_TGT, ST_ENT_RD, ST_ENT_CAP, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQE,
      ST_NORM, ST_ZERO, ST_SEED0, ST_SEED1, ST_NW_YY, ST_NW_NY, ST_NW_F, ST_NW_YF,
      ST_NW_UPD, ST_CUBE0, ST_CUBE1, ST_CUBE2, ST_W, ST_TM, ST_TS, ST_TA, ST_OUT
   } sga_state_type;

   typedef enum logic [4:0] {
      OP_IDLE, OP_EPS, OP_TGT, OP_ENT_RD, OP_ENT_CAP, OP_SQ0, OP_SQ1, OP_SQ2, OP_SQE,
      OP_NORM, OP_ZERO, OP_SEED0, OP_SEED1, OP_NW_YY, OP_NW_NY, OP_NW_F, OP_NW_YF,
      OP_NW_UPD, OP_CUBE0, OP_CUBE1, OP_CUBE2, OP_W, OP_TM, OP_TS, OP_TA, OP_OUT
   } sga_op_type;

   typedef struct packed {
      sga_op_type op;
   } sga_cmd_type;

   typedef struct packed {
      logic entries_done;
      logic skip;
      logic s_zero;
      logic norm_ok;
      logic newton_last;
      logic k_last;
   } sga_status_type;

endpackage

@@ rtl/sga_ram.sv @@
module sga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sga_ctrl.sv @@
module sga_ctrl import sga_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           req_type,
   input  sga_status_type status,
   output sga_cmd_type    cmd,
   output logic           busy
);

   sga_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_type == REQ_QUERY) begin
               state_in = ST_EPS;
            end
         end
         ST_EPS:     state_in = ST_TGT;
         ST_TGT:     state_in = ST_ENT_RD;
         ST_ENT_RD:  state_in = status.entries_done ? ST_OUT : ST_ENT_CAP;
         ST_ENT_CAP: state_in = ST_SQ0;
         ST_SQ0:     state_in = status.skip ? ST_ENT_RD : ST_SQ1;
         ST_SQ1:     state_in = ST_SQ2;
         ST_SQ2:     state_in = ST_SQE;
         ST_SQE:     state_in = ST_NORM;
         ST_NORM: begin
            if (status.s_zero) begin
               state_in = ST_ZERO;
            end else if (status.norm_ok) begin
               state_in = ST_SEED0;
            end
         end
         ST_ZERO:    state_in = ST_ENT_RD;
         ST_SEED0:   state_in = ST_SEED1;
         ST_SEED1:   state_in = ST_NW_YY;
         ST_NW_YY:   state_in = ST_NW_NY;
         ST_NW_NY:   state_in = ST_NW_F;
         ST_NW_F:    state_in = ST_NW_YF;
         ST_NW_YF:   state_in = ST_NW_UPD;
         ST_NW_UPD:  state_in = status.newton_last ? ST_CUBE0 : ST_NW_YY;
         ST_CUBE0:   state_in = ST_CUBE1;
         ST_CUBE1:   state_in = ST_CUBE2;
         ST_CUBE2:   state_in = ST_W;
         ST_W:       state_in = ST_TM;
         ST_TM:      state_in = ST_TS;
         ST_TS:      state_in = ST_TA;
         ST_TA:      state_in = status.k_last ? ST_ENT_RD : ST_TM;
         ST_OUT:     state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy = 1'b1;
      cmd.op = OP_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.op = OP_IDLE;
         end
         ST_EPS:     cmd.op = OP_EPS;
         ST_TGT:     cmd.op = OP_TGT;
         ST_ENT_RD:  cmd.op = OP_ENT_RD;
         ST_ENT_CAP: cmd.op = OP_ENT_CAP;
         ST_SQ0:     cmd.op = OP_SQ0;
         ST_SQ1:     cmd.op = OP_SQ1;
         ST_SQ2:     cmd.op = OP_SQ2;
         ST_SQE:     cmd.op = OP_SQE;
         ST_NORM:    cmd.op = OP_NORM;
         ST_ZERO:    cmd.op = OP_ZERO;
         ST_SEED0:   cmd.op = OP_SEED0;
         ST_SEED1:   cmd.op = OP_SEED1;
         ST_NW_YY:   cmd.op = OP_NW_YY;
         ST_NW_NY:   cmd.op = OP_NW_NY;
         ST_NW_F:    cmd.op = OP_NW_F;
         ST_NW_YF:   cmd.op = OP_NW_YF;
         ST_NW_UPD:  cmd.op = OP_NW_UPD;
         ST_CUBE0:   cmd.op = OP_CUBE0;
         ST_CUBE1:   cmd.op = OP_CUBE1;
         ST_CUBE2:   cmd.op = OP_CUBE2;
         ST_W:       cmd.op = OP_W;
         ST_TM:      cmd.op = OP_TM;
         ST_TS:      cmd.op = OP_TS;
         ST_TA:      cmd.op = OP_TA;
         ST_OUT:     cmd.op = OP_OUT;
         default:    cmd.op = OP_IDLE;
      endcase
   end

endmodule

@@ rtl/sga_datapath.sv @@
module sga_datapath import sga_pkg::*; #(
   parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
   parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  sga_req_type                      req_data,
   input  logic [COORD_W-1:0]               softening_length,
   input  logic [COUNT_W-1:0]               active_count,
   input  sga_cmd_type                      cmd,
   output sga_status_type                   status,
   output logic                             ram_wr_en,
   output logic [$clog2(MAX_PARTICLES)-1:0] ram_wr_addr,
   output logic [ENTRY_W-1:0]               ram_wr_data,
   output logic [$clog2(MAX_PARTICLES)-1:0] ram_rd_addr,
   input  logic [ENTRY_W-1:0]               ram_rd_data,
   output logic                             rsp_valid,
   output sga_rsp_type                      rsp_data
);

   localparam int IDX_W = $clog2(MAX_PARTICLES);
   localparam int IT_W = $clog2(NEWTON_STEPS + 1);
   localparam int S_W = 50;
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;
   localparam logic [31:0] SEED_HI = 32'd759250125;
   localparam logic [33:0] THREE_Q30 = 34'd3221225472;
   localparam logic [46:0] ACC_MAX = {47{1'b1}};
   localparam logic signed [ACC_W-1:0] ACC_MAX_S = {1'b0, ACC_MAX};
   localparam logic signed [ACC_W-1:0] ACC_MIN_S = {1'b1, 47'd0};

   function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                              input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] sum;
      logic [ACC_W:0] res;
      sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         res = {1'b1, (sum[ACC_W] ? ACC_MIN_S : ACC_MAX_S)};
      end else begin
         res = {1'b0, sum[ACC_W-1:0]};
      end
      return res;
   endfunction

   logic [SLOT_W-1:0]          slot_ff;
   logic                       in_table_ff;
   logic [COUNT_W-1:0]         j_ff;
   logic signed [COORD_W-1:0]  pi_ff [3];
   logic [47:0]                eps2_ff;
   logic [MASS_W-1:0]          m_ff;
   logic [31:0]                ad_ff [3];
   logic                       neg_ff [3];
   logic                       nz_ff [3];
   logic                       skip_ff;
   logic [63:0]                mul_ff;
   logic [S_W-1:0]             s_ff;
   logic signed [4:0]          half_ff;
   logic [31:0]                y_ff;
   logic [31:0]                f_ff;
   logic [IT_W-1:0]            it_ff;
   logic [31:0]                w_ff;
   logic signed [6:0]          sh_ff;
   logic [1:0]                 k_ff;
   logic signed [ACC_W-1:0]    term_ff;
   logic                       over_ff;
   logic signed [ACC_W-1:0]    acc_ff [3];
   logic                       flag_ff;
   logic                       rsp_valid_ff;
   sga_rsp_type                rsp_ff;

   logic [31:0]                mul_a, mul_b;
   logic [COUNT_W-1:0]         count;
   logic                       req_in_table;
   logic signed [COORD_W-1:0]  pj [3];
   logic signed [COORD_W:0]    delta [3];
   logic [63:0]                shr, shl, chk;
   logic [5:0]                 lk;
   logic                       over;
   logic [46:0]                mag;
   logic [33:0]                tval;
   logic [ACC_W:0]             ta_sum;
   logic [ACC_W:0]             zs [3];

   assign count = (32'(active_count) > 32'(MAX_PARTICLES)) ? COUNT_W'(MAX_PARTICLES)
                                                           : active_count;
   assign req_in_table = 32'(req_data.slot) < 32'(MAX_PARTICLES);

   assign pj[0] = ram_rd_data[31:0];
   assign pj[1] = ram_rd_data[63:32];
   assign pj[2] = ram_rd_data[95:64];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         delta[k] = {pj[k][COORD_W-1], pj[k]} - {pi_ff[k][COORD_W-1], pi_ff[k]};
      end
   end

   assign ram_wr_en = (cmd.op == OP_IDLE) && start && (req_data.req_type == REQ_WRITE)
                      && req_in_table;
   assign ram_wr_addr = IDX_W'(req_data.slot);
   assign ram_wr_data = {req_data.body_mass, req_data.pos_z, req_data.pos_y, req_data.pos_x};
   assign ram_rd_addr = (cmd.op == OP_EPS) ? IDX_W'(slot_ff) : IDX_W'(j_ff);

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      unique case (cmd.op) inside
         OP_EPS: begin
            mul_a = softening_length;
            mul_b = softening_length;
         end
         OP_SQ0: begin
            mul_a = ad_ff[0];
            mul_b = ad_ff[0];
         end
         OP_SQ1: begin
            mul_a = ad_ff[1];
            mul_b = ad_ff[1];
         end
         OP_SQ2: begin
            mul_a = ad_ff[2];
            mul_b = ad_ff[2];
         end
         OP_SEED0: begin
            if (s_ff[31]) begin
               mul_a = {1'b0, s_ff[30:0]};
               mul_b = 32'd6786;
            end else begin
               mul_a = {2'b00, s_ff[29:0]};
               mul_b = 32'd19195;
            end
         end
         OP_NW_YY, OP_CUBE0: begin
            mul_a = y_ff;
            mul_b = y_ff;
         end
         OP_NW_NY: begin
            mul_a = s_ff[31:0];
            mul_b = mul_ff[61:30];
         end
         OP_NW_YF: begin
            mul_a = y_ff;
            mul_b = f_ff;
         end
         OP_CUBE1: begin
            mul_a = mul_ff[61:30];
            mul_b = y_ff;
         end
         OP_CUBE2: begin
            mul_a = m_ff;
            mul_b = mul_ff[61:30];
         end
         OP_TM: begin
            mul_a = w_ff;
            mul_b = ad_ff[k_ff];
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   always_comb begin
      lk = 6'(-sh_ff);
      shr = mul_ff >> sh_ff[5:0];
      shl = mul_ff << lk;
      chk = mul_ff >> (6'd47 - lk);
      if (!sh_ff[6]) begin
         over = shr[63:47] != '0;
         mag = over ? ACC_MAX : shr[46:0];
      end else begin
         over = chk != '0;
         mag = over ? ACC_MAX : shl[46:0];
      end
      tval = mul_ff[63:30];
      ta_sum = sat_add(acc_ff[k_ff], term_ff);
      for (int k = 0; k < 3; k++) begin
         zs[k] = sat_add(acc_ff[k], neg_ff[k] ? -ACC_MAX_S : ACC_MAX_S);
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      unique case (cmd.op)
         OP_IDLE: begin
            if (start && req_data.req_type == REQ_QUERY) begin
               slot_ff <= req_data.slot;
               in_table_ff <= req_in_table;
               flag_ff <= 1'b0;
               for (int k = 0; k < 3; k++) begin
                  acc_ff[k] <= '0;
               end
            end
         end
         OP_TGT: begin
            pi_ff[0] <= in_table_ff ? pj[0] : '0;
            pi_ff[1] <= in_table_ff ? pj[1] : '0;
            pi_ff[2] <= in_table_ff ? pj[2] : '0;
            eps2_ff <= mul_ff[63:16];
            j_ff <= '0;
         end
         OP_ENT_CAP: begin
            m_ff <= ram_rd_data[127:96];
            skip_ff <= (ram_rd_data[127:96] == '0) || (in_table_ff && j_ff == {1'b0, slot_ff});
            for (int k = 0; k < 3; k++) begin
               neg_ff[k] <= delta[k][COORD_W];
               nz_ff[k] <= delta[k] != '0;
               ad_ff[k] <= delta[k][COORD_W] ? 32'(-delta[k]) : delta[k][31:0];
            end
         end
         OP_SQ0: begin
            if (skip_ff) begin
               j_ff <= j_ff + 1'b1;
            end
         end
         OP_SQ1: s_ff <= S_W'(eps2_ff) + S_W'(mul_ff[63:16]);
         OP_SQ2: s_ff <= s_ff + S_W'(mul_ff[63:16]);
         OP_SQE: begin
            s_ff <= s_ff + S_W'(mul_ff[63:16]);
            half_ff <= '0;
         end
         OP_NORM: begin
            if (s_ff[S_W-1:32] != '0) begin
               s_ff <= s_ff >> 2;
               half_ff <= half_ff + 5'sd1;
            end else if (s_ff[31:30] == 2'b00) begin
               s_ff <= s_ff << 2;
               half_ff <= half_ff - 5'sd1;
            end
         end
         OP_ZERO: begin
            flag_ff <= 1'b1;
            for (int k = 0; k < 3; k++) begin
               if (nz_ff[k]) begin
                  acc_ff[k] <= zs[k][ACC_W-1:0];
               end
            end
            j_ff <= j_ff + 1'b1;
         end
         OP_SEED1: begin
            y_ff <= (s_ff[31] ? SEED_HI : Q30_ONE) - mul_ff[47:16];
            it_ff <= '0;
         end
         OP_NW_F: f_ff <= (tval < THREE_Q30) ? 32'(THREE_Q30 - tval) : 32'd0;
         OP_NW_UPD: begin
            y_ff <= mul_ff[62:31];
            it_ff <= it_ff + 1'b1;
         end
         OP_W: begin
            w_ff <= mul_ff[62:31];
            sh_ff <= 7'sd19 + 7'(half_ff) * 7'sd3;
            k_ff <= '0;
         end
         OP_TS: begin
            term_ff <= neg_ff[k_ff] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            over_ff <= over;
         end
         OP_TA: begin
            acc_ff[k_ff] <= ta_sum[ACC_W-1:0];
            flag_ff <= flag_ff | over_ff | ta_sum[ACC_W];
            k_ff <= k_ff + 1'b1;
            if (k_ff == 2'd2) begin
               j_ff <= j_ff + 1'b1;
            end
         end
         OP_OUT: begin
            rsp_ff.acc_x <= acc_ff[0];
            rsp_ff.acc_y <= acc_ff[1];
            rsp_ff.acc_z <= acc_ff[2];
            rsp_ff.overflow_flag <= flag_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.op == OP_OUT;
      end
   end

   assign status.entries_done = j_ff >= count;
   assign status.skip = skip_ff;
   assign status.s_zero = s_ff == '0;
   assign status.norm_ok = (s_ff[S_W-1:32] == '0) && (s_ff[31:30] != 2'b00);
   assign status.newton_last = it_ff == IT_W'(NEWTON_STEPS - 1);
   assign status.k_last = k_ff == 2'd2;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ rtl/softened_gravity_accumulator.sv @@
// A write item stores one particle entry. A query has a fixed overhead and,
// for each active entry, skips it when it is the target or has zero mass,
// takes a short path when its denominator is zero, and otherwise runs the
// squared distance, a normalizing step of two bits a cycle, the seed and the
// Newton steps, the cube and weight, and a multiply, shift and add per
// acceleration component, all sharing one 32 x 32 multiplier. The result is
// shown on rsp_data for exactly one cycle with rsp_valid high and must be
// taken then; the block is idle again in that same cycle.
module softened_gravity_accumulator import sga_pkg::*; #(
   parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
   parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sga_req_type          req_data,
   output logic                 rsp_valid,
   output sga_rsp_type          rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int IDX_W = $clog2(MAX_PARTICLES);

   logic [COORD_W-1:0] softening_ff;
   logic [COUNT_W-1:0] active_ff;
   sga_cmd_type        cmd;
   sga_status_type     status;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         softening_ff <= '0;
         active_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOFTENING: softening_ff <= csr_data;
            CSR_ACTIVE:    active_ff <= csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sga_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_data.req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   sga_datapath #(
      .MAX_PARTICLES (MAX_PARTICLES),
      .NEWTON_STEPS  (NEWTON_STEPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_data         (req_data),
      .softening_length (softening_ff),
      .active_count     (active_ff),
      .cmd              (cmd),
      .status           (status),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data)
   );

   sga_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PARTICLES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

@@ rtl/sga_checker.sv @@
`include "assert_macros.svh"

module sga_checker import sga_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input sga_req_type req_data,
   input logic        rsp_valid,
   input logic        csr_valid,
   input logic        csr_ready
);

   logic query_transfer, write_transfer;

   assign query_transfer = start && !busy && (req_data.req_type == REQ_QUERY);
   assign write_transfer = start && !busy && (req_data.req_type == REQ_WRITE);

   // A result is shown only once the block has gone idle again.
   `SGA_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy)
   // Results are single-cycle strobes, never back to back.
   `SGA_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   // A query transfer always starts work.
   `SGA_ASSERT_NEXT(a_query_busy, query_transfer, busy && !rsp_valid)
   // A write transfer gives no result and leaves the block idle.
   `SGA_ASSERT_NEXT(a_write_idle, write_transfer, !busy && !rsp_valid)
   // Register writes are never held off.
   `SGA_ASSERT_SAME(a_csr_ready, csr_valid, csr_ready)

endmodule

bind softened_gravity_accumulator sga_checker u_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import sga_pkg::*;

   localparam longint signed ACC_TOP = 64'sd140737488355327;
   localparam longint signed ACC_BOT = -64'sd140737488355328;
   localparam longint unsigned Q30 = 64'd1073741824;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   sga_req_type req_data = '0;
   logic rsp_valid;
   sga_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SOFTENING;
   logic [31:0] csr_data = '0;

   softened_gravity_accumulator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sga_req_type pending_reqs[$];
   sga_rsp_type expected_accels[$];
   logic [31:0] mass_tbl[MAX_PARTICLES_DEF];
   longint signed pos_tbl[MAX_PARTICLES_DEF][3];
   logic [31:0] eps_reg = '0;
   logic [6:0] count_reg = '0;
   int errors = 0;
   int gap_left = 0;
   bit no_idle = 1'b0;

   function automatic void add_pending(input sga_req_type r);
      pending_reqs = {pending_reqs, r};
   endfunction

   function automatic void add_expected(input sga_rsp_type r);
      expected_accels = {expected_accels, r};
   endfunction

   function automatic longint unsigned inv_cube(input longint unsigned s, output int half);
      int p;
      int q;
      longint unsigned n, y, t, f, y2;
      p = 0;
      while (p < 63 && (s >> (p + 1)) != 0)
         p++;
      q = p - 30;
      if (p % 2 == 1)
         q -= 1;
      n = (q >= 0) ? (s >> q) : (s << (-q));
      half = q / 2;
      if (n < 2 * Q30)
         y = Q30 - (((n - Q30) * 64'd19195) >> 16);
      else
         y = 64'd759250125 - (((n - 2 * Q30) * 64'd6786) >> 16);
      for (int i = 0; i < NEWTON_STEPS_DEF; i++) begin
         y2 = (y * y) >> 30;
         t = (n * y2) >> 30;
         f = (t < 3 * Q30) ? (3 * Q30 - t) : 64'd0;
         y = (y * f) >> 31;
      end
      y2 = (y * y) >> 30;
      return (y2 * y) >> 30;
   endfunction

   function automatic longint signed sat_sum(input longint signed a, input longint signed b,
                                             inout bit flag);
      longint signed r;
      r = a + b;
      if (r > ACC_TOP) begin
         flag = 1'b1;
         return ACC_TOP;
      end
      if (r < ACC_BOT) begin
         flag = 1'b1;
         return ACC_BOT;
      end
      return r;
   endfunction

   function automatic sga_rsp_type gravity_at(input int tgt);
      longint signed acc[3];
      longint signed d[3];
      longint unsigned ad[3];
      longint unsigned s, eps2, m, y3, w, pr, r;
      int cnt, half, sh;
      bit flag;
      sga_rsp_type res;
      acc = '{0, 0, 0};
      flag = 1'b0;
      cnt = (count_reg > MAX_PARTICLES_DEF) ? MAX_PARTICLES_DEF : count_reg;
      eps2 = (longint'(eps_reg) * longint'(eps_reg)) >> 16;
      for (int j = 0; j < cnt; j++) begin
         m = mass_tbl[j];
         if (j == tgt || m == 0)
            continue;
         s = eps2;
         for (int k = 0; k < 3; k++) begin
            d[k] = pos_tbl[j][k] - pos_tbl[tgt][k];
            ad[k] = d[k] < 0 ? -d[k] : d[k];
            s += (ad[k] * ad[k]) >> 16;
         end
         if (s == 0) begin
            flag = 1'b1;
            for (int k = 0; k < 3; k++)
               if (d[k] != 0)
                  acc[k] = sat_sum(acc[k], d[k] < 0 ? -ACC_TOP : ACC_TOP, flag);
            continue;
         end
         y3 = inv_cube(s, half);
         w = (m * y3) >> 31;
         sh = 19 + 3 * half;
         for (int k = 0; k < 3; k++) begin
            pr = w * ad[k];
            if (sh >= 0)
               r = pr >> sh;
            else if (pr > (longint'(ACC_TOP) >> (-sh)))
               r = ACC_TOP + 1;
            else
               r = pr << (-sh);
            if (r > ACC_TOP) begin
               r = ACC_TOP;
               flag = 1'b1;
            end
            acc[k] = sat_sum(acc[k], d[k] < 0 ? -longint'(r) : longint'(r), flag);
         end
      end
      res.acc_x = ACC_W'(acc[0]);
      res.acc_y = ACC_W'(acc[1]);
      res.acc_z = ACC_W'(acc[2]);
      res.overflow_flag = flag;
      return res;
   endfunction

   always @(posedge clock) begin
      logic next_start;
      sga_req_type item;
      int roll;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            if (req_data.req_type == REQ_WRITE) begin
               mass_tbl[req_data.slot] = req_data.body_mass;
               pos_tbl[req_data.slot][0] = req_data.pos_x;
               pos_tbl[req_data.slot][1] = req_data.pos_y;
               pos_tbl[req_data.slot][2] = req_data.pos_z;
            end else begin
               add_expected(gravity_at(req_data.slot));
            end
            next_start = 1'b0;
            roll = $urandom_range(99);
            if (no_idle || roll < 60)
               gap_left = 0;
            else if (roll < 90)
               gap_left = $urandom_range(3, 1);
            else
               gap_left = $urandom_range(40, 10);
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               item = pending_reqs.pop_front();
               req_data <= item;
               next_start = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   always @(posedge clock) begin
      sga_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_accels.size() == 0) begin
            $display("%0t: result with none expected, actual %h", $time, rsp_data);
            errors++;
         end else begin
            exp_rsp = expected_accels.pop_front();
            if (rsp_data.acc_x !== exp_rsp.acc_x) begin
               $display("%0t: acc_x expected %h actual %h", $time, exp_rsp.acc_x,
                        rsp_data.acc_x);
               errors++;
            end
            if (rsp_data.acc_y !== exp_rsp.acc_y) begin
               $display("%0t: acc_y expected %h actual %h", $time, exp_rsp.acc_y,
                        rsp_data.acc_y);
               errors++;
            end
            if (rsp_data.acc_z !== exp_rsp.acc_z) begin
               $display("%0t: acc_z expected %h actual %h", $time, exp_rsp.acc_z,
                        rsp_data.acc_z);
               errors++;
            end
            if (rsp_data.overflow_flag !== exp_rsp.overflow_flag) begin
               $display("%0t: overflow_flag expected %b actual %b", $time,
                        exp_rsp.overflow_flag, rsp_data.overflow_flag);
               errors++;
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || start || expected_accels.size() > 0 || busy)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      if (idx == CSR_SOFTENING)
         eps_reg = val;
      else if (idx == CSR_ACTIVE)
         count_reg = val[6:0];
      csr_valid <= 1'b0;
   endtask

   function automatic sga_req_type particle(input logic [5:0] slot);
      sga_req_type r;
      int mode;
      logic [31:0] base;
      r.req_type = REQ_WRITE;
      r.slot = slot;
      case ($urandom_range(9))
         0: r.body_mass = '0;
         1: r.body_mass = '1;
         2, 3: r.body_mass = $urandom_range(32'hFFFF);
         default: r.body_mass = $urandom;
      endcase
      mode = $urandom_range(9);
      base = $urandom_range(32'h00FF_FFFF);
      r.pos_x = 32'((mode < 2) ? $urandom : (mode < 6) ? base + $urandom_range(32'h1FF_FFFF)
              : (mode < 8) ? $urandom_range(511) : pos_tbl[$urandom_range(7)][0]);
      r.pos_y = 32'((mode < 2) ? $urandom : (mode < 6) ? -base + $urandom_range(32'h1FF_FFFF)
              : (mode < 8) ? -$urandom_range(511) : pos_tbl[$urandom_range(7)][1]);
      r.pos_z = 32'((mode < 2) ? $urandom : (mode < 6) ? base - $urandom_range(32'h1FF_FFFF)
              : (mode < 8) ? $urandom_range(511) : pos_tbl[$urandom_range(7)][2]);
      return r;
   endfunction

   function automatic sga_req_type query(input logic [5:0] slot);
      sga_req_type r;
      r.req_type = REQ_QUERY;
      r.slot = slot;
      r.body_mass = $urandom;
      r.pos_x = $urandom;
      r.pos_y = $urandom;
      r.pos_z = $urandom;
      return r;
   endfunction

   initial begin
      sga_req_type r;
      int n_items, cnt_sel;
      logic [31:0] eps_val;
      logic [6:0] cnt_val;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_SOFTENING, '0);
      write_csr(CSR_ACTIVE, 32'd5);
      for (int i = 0; i < MAX_PARTICLES_DEF; i++)
         add_pending(particle(6'(i)));
      r = particle(6'd0);
      r.body_mass = '1;
      r.pos_x = 32'sh7FFF_FFFF;
      r.pos_y = -32'sh8000_0000;
      r.pos_z = '0;
      add_pending(r);
      r.slot = 6'd1;
      r.pos_x = -32'sh8000_0000;
      r.pos_y = 32'sh7FFF_FFFF;
      add_pending(r);
      r.slot = 6'd2;
      r.pos_x = 32'sh0000_0100;
      r.pos_y = 32'sh0000_0100;
      r.pos_z = 32'sh0000_0100;
      add_pending(r);
      r.slot = 6'd3;
      add_pending(r);
      r.slot = 6'd4;
      r.body_mass = '0;
      add_pending(r);
      for (int i = 0; i < 5; i++)
         add_pending(query(6'(i)));
      add_pending(query(6'd63));
      wait_idle();
      write_csr(CSR_ACTIVE, 32'd0);
      add_pending(query(6'd0));
      wait_idle();
      write_csr(CSR_SOFTENING, 32'hFFFF_FFFF);
      write_csr(CSR_ACTIVE, 32'd127);
      add_pending(query(6'd2));
      add_pending(query(6'd40));
      wait_idle();
      for (int ph = 0; ph < 16; ph++) begin
         cnt_sel = $urandom_range(9);
         cnt_val = (cnt_sel == 0) ? 7'd64 : (cnt_sel == 1) ? 7'($urandom_range(127, 65))
                 : (cnt_sel == 2) ? 7'($urandom_range(1)) : 7'($urandom_range(10, 2));
         case ($urandom_range(4))
            0: eps_val = '0;
            1: eps_val = '1;
            2: eps_val = $urandom;
            default: eps_val = $urandom_range(32'h00FF_FFFF);
         endcase
         write_csr(CSR_SOFTENING, eps_val);
         write_csr(CSR_ACTIVE, 32'(cnt_val));
         no_idle = (ph % 4 == 3);
         n_items = (cnt_sel < 2) ? 30 : 90;
         for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(1))
               add_pending(particle(6'($urandom_range(
                  ($urandom_range(3) == 0) ? 63 : 11))));
            else
               add_pending(query(6'($urandom_range(
                  ($urandom_range(3) == 0) ? 63 : 11))));
         end
         wait_idle();
      end
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #300ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
